// File: src/fat12_file_sector_walker_macros.svh
// Assertion macros for the FAT12 file sector walker.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef FAT12_FILE_SECTOR_WALKER_MACROS_SVH
`define FAT12_FILE_SECTOR_WALKER_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define FSW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be true outside reset
`define FSW_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FSW_ASSERT(lbl, prop, msg)
`define FSW_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: src/fat12w_pkg.sv
// Shared types and constants for the FAT12 file sector walker.
// No dependencies; imported by every module of the block.
`default_nettype none

package fat12w_pkg;

    // operation codes
    localparam logic [1:0] OP_FAT_WR = 2'd0;
    localparam logic [1:0] OP_DIR_WR = 2'd1;
    localparam logic [1:0] OP_OPEN   = 2'd2;
    localparam logic [1:0] OP_NEXT   = 2'd3;

    // result status codes
    localparam logic [1:0] STS_OK          = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND   = 2'd1;
    localparam logic [1:0] STS_NOT_OPEN    = 2'd2;
    localparam logic [1:0] STS_BAD_CLUSTER = 2'd3;

    localparam logic [7:0]  DELETED_MARK   = 8'hE5;
    localparam logic [7:0]  LFN_ATTR       = 8'h0F;
    localparam logic [11:0] EOC_FIRST      = 12'hFF8;
    localparam logic [11:0] RESERVED_FIRST = 12'hFF0;
    localparam logic [11:0] OFFSET_RESET   = 12'd31;
    localparam int          NAME_BYTES     = 11;

    typedef struct packed {
        logic [63:0] name_head;
        logic [23:0] name_tail;
        logic [7:0]  attributes;
        logic [11:0] first_cluster;
        logic [31:0] file_size;
    } dir_entry_t;

    typedef struct packed {
        logic [12:0] sector;
        logic [9:0]  count;
        logic [31:0] left;
    } step_res_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  found_slot;
        logic [11:0] cluster_out;
        logic [31:0] size_out;
        logic [12:0] sector;
        logic [9:0]  byte_count;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// File: src/fat12w_dir_store.sv
// Root directory storage: one write port, one registered read port.
// Per-slot valid bits make unwritten slots read as all zero. Uses fat12w_pkg.
`default_nettype none

module fat12w_dir_store
    import fat12w_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire dir_entry_t               wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output dir_entry_t                    rd_data
);

    dir_entry_t             mem [DEPTH];
    logic [DEPTH-1:0]       vld_reg;
    dir_entry_t             rd_data_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// File: src/fat12w_fat_store.sv
// FAT link table: one write port, one registered read port.
// Contents are undefined until written. Uses fat12w_pkg.
`default_nettype none

module fat12w_fat_store
    import fat12w_pkg::*;
#(
    parameter int DEPTH = 4096
)
(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [11:0]              wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [11:0]                   rd_data
);

    logic [11:0] mem [DEPTH];
    logic [11:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/fat12w_name_match.sv
// Directory slot compare unit: skip rules plus 11-byte name compare.
// Shared by every slot of a scan, one slot per cycle. Uses fat12w_pkg.
`default_nettype none

module fat12w_name_match
    import fat12w_pkg::*;
(
    input  wire dir_entry_t   entry,
    input  wire logic [63:0]  key_head,
    input  wire logic [23:0]  key_tail,
    output logic              hit
);

    logic [87:0] ename;
    logic [87:0] kname;
    logic        skip;
    logic        same;

    assign ename = {entry.name_head, entry.name_tail};
    assign kname = {key_head, key_tail};
    assign skip  = (entry.name_head[63:56] == DELETED_MARK) ||
                   (entry.name_head[63:56] == 8'h00) ||
                   (entry.attributes == LFN_ATTR);

    // compare stops with a match at the first shared zero byte
    always_comb
    begin
        logic       stop;
        logic [7:0] a;
        logic [7:0] b;
        stop = 1'b0;
        same = 1'b1;
        for (int k = 0; k < NAME_BYTES; k++)
        begin
            a = ename[87 - 8*k -: 8];
            b = kname[87 - 8*k -: 8];
            if (!stop)
            begin
                if (a != b)
                begin
                    same = 1'b0;
                    stop = 1'b1;
                end
                else if (a == 8'h00)
                begin
                    stop = 1'b1;
                end
            end
        end
    end

    assign hit = !skip && same;

endmodule

`default_nettype wire

// File: src/fat12w_step_unit.sv
// Shared arithmetic unit: sector = cluster + offset, and the byte take
// min(remaining, sector size) with the bytes left after it. Uses fat12w_pkg.
`default_nettype none

module fat12w_step_unit
    import fat12w_pkg::*;
#(
    parameter int SECTOR_BYTES = 512
)
(
    input  wire logic [11:0] cluster,
    input  wire logic [11:0] offset,
    input  wire logic [31:0] remaining,
    output step_res_t        res
);

    localparam logic [31:0] SECTOR_W = 32'(SECTOR_BYTES);

    logic [31:0] take;

    assign take       = (remaining < SECTOR_W) ? remaining : SECTOR_W;
    assign res.sector = {1'b0, cluster} + {1'b0, offset};
    assign res.count  = take[9:0];
    assign res.left   = remaining - take;

endmodule

`default_nettype wire

// File: src/fat12_file_sector_walker.sv
// FAT12 file sector walker, top level. Sequencer around the directory and
// FAT stores, the name compare unit and the step unit. Uses fat12w_pkg.
// Usage
//   Input channel (in_valid/in_ready) carries one operation per beat:
//   write FAT entry, write directory slot, open by name, next sector.
//   Output channel (out_valid/out_ready) returns exactly one result beat
//   per input beat, in order. cfg_valid/cfg_data writes data_offset; it is
//   always ready and should only be written while the block is idle.
// Sequence
//   Writes: from accept through S_DONE to the result. Next: through S_FATW
//   (one FAT read) and S_DONE, or S_DONE alone when no file is open or the
//   cluster is bad. Open: one directory slot per cycle through the registered
//   read port, ending early when a slot matches. in_ready is low while an
//   item is in progress.
// Reset
//   Directory slots read as empty, no file is open, data_offset is 31.
//   FAT entries are undefined until written. No clearing pass is needed.
// Stall
//   A finished result sits in the output register; the next item is still
//   accepted and worked on, and its result waits until the register frees.
`default_nettype none

`include "fat12_file_sector_walker_macros.svh"

module fat12_file_sector_walker
    import fat12w_pkg::*;
#(
    parameter int DIR_ENTRIES  = 256,
    parameter int FAT_ENTRIES  = 4096,
    parameter int SECTOR_BYTES = 512
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data,
    // input beats
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [11:0] slot_index,
    input  wire logic [11:0] link_value,
    input  wire logic [63:0] name_head,
    input  wire logic [23:0] name_tail,
    input  wire logic [7:0]  attributes,
    input  wire logic [11:0] start_cluster,
    input  wire logic [31:0] byte_size,
    // result beats
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [7:0]       found_slot,
    output logic [11:0]      cluster_out,
    output logic [31:0]      size_out,
    output logic [12:0]      sector,
    output logic [9:0]       byte_count,
    output logic             last
);

    localparam int DAW = $clog2(DIR_ENTRIES);
    localparam int FAW = $clog2(FAT_ENTRIES);
    localparam int CW  = $clog2(DIR_ENTRIES + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FATW = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [DAW-1:0] cmp_slot_reg, cmp_slot_next;
    logic [11:0]   cursor_reg, cursor_next;
    logic [31:0]   bytes_left_reg, bytes_left_next;
    logic          file_open_reg, file_open_next;
    logic [11:0]   offset_reg, offset_next;
    logic          out_valid_reg, out_valid_next;
    result_t       res_reg, res_next;
    result_t       out_res_reg, out_res_next;
    logic [63:0]   key_head_reg, key_head_next;
    logic [23:0]   key_tail_reg, key_tail_next;

    logic          accept;
    logic          fat_wr_en;
    logic          dir_wr_en;
    dir_entry_t    dir_wr_data;
    logic          dir_rd_en;
    dir_entry_t    dir_rd_data;
    logic          fat_rd_en;
    logic [11:0]   fat_rd_data;
    logic          slot_hit;
    logic          cursor_bad;
    logic [11:0]   su_cluster;
    step_res_t     su_res;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // writes land on the accept edge, straight from the ports
    assign fat_wr_en = accept && (operation == OP_FAT_WR) &&
                       ({1'b0, slot_index} < 13'(FAT_ENTRIES));
    assign dir_wr_en = accept && (operation == OP_DIR_WR) &&
                       ({1'b0, slot_index} < 13'(DIR_ENTRIES));

    assign dir_wr_data.name_head     = name_head;
    assign dir_wr_data.name_tail     = name_tail;
    assign dir_wr_data.attributes    = attributes;
    assign dir_wr_data.first_cluster = start_cluster;
    assign dir_wr_data.file_size     = byte_size;

    // cluster 0/1, beyond the table, or reserved range is unusable
    assign cursor_bad = (cursor_reg < 12'd2) ||
                        ({1'b0, cursor_reg} >= 13'(FAT_ENTRIES)) ||
                        (cursor_reg >= RESERVED_FIRST);

    assign fat_rd_en = accept && (operation == OP_NEXT) && file_open_reg && !cursor_bad;
    assign dir_rd_en = (state_reg == S_SCAN) && (scan_cnt_reg < CW'(DIR_ENTRIES));

    // step unit serves both the open hit and the next step
    assign su_cluster = (state_reg == S_SCAN) ? dir_rd_data.first_cluster : cursor_reg;

    fat12w_dir_store #(
        .DEPTH (DIR_ENTRIES)
    ) u_dir (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (dir_wr_en),
        .wr_addr (slot_index[DAW-1:0]),
        .wr_data (dir_wr_data),
        .rd_en   (dir_rd_en),
        .rd_addr (scan_cnt_reg[DAW-1:0]),
        .rd_data (dir_rd_data)
    );

    fat12w_fat_store #(
        .DEPTH (FAT_ENTRIES)
    ) u_fat (
        .clk     (clk),
        .wr_en   (fat_wr_en),
        .wr_addr (slot_index[FAW-1:0]),
        .wr_data (link_value),
        .rd_en   (fat_rd_en),
        .rd_addr (cursor_reg[FAW-1:0]),
        .rd_data (fat_rd_data)
    );

    fat12w_name_match u_match (
        .entry    (dir_rd_data),
        .key_head (key_head_reg),
        .key_tail (key_tail_reg),
        .hit      (slot_hit)
    );

    fat12w_step_unit #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_step (
        .cluster   (su_cluster),
        .offset    (offset_reg),
        .remaining (bytes_left_reg),
        .res       (su_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_slot_next   = cmp_slot_reg;
        cursor_next     = cursor_reg;
        bytes_left_next = bytes_left_reg;
        file_open_next  = file_open_reg;
        offset_next     = offset_reg;
        out_valid_next  = out_valid_reg;
        res_next        = res_reg;
        out_res_next    = out_res_reg;
        key_head_next   = key_head_reg;
        key_tail_next   = key_tail_reg;

        if (cfg_valid && cfg_ready)
        begin
            offset_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_head_next = name_head;
                    key_tail_next = name_tail;
                    res_next      = '0;
                    case (operation)
                        OP_FAT_WR, OP_DIR_WR:
                        begin
                            state_next = S_DONE;
                        end
                        OP_OPEN:
                        begin
                            scan_cnt_next = '0;
                            cmp_vld_next  = 1'b0;
                            state_next    = S_SCAN;
                        end
                        default:
                        begin
                            if (!file_open_reg)
                            begin
                                res_next.status = STS_NOT_OPEN;
                                state_next      = S_DONE;
                            end
                            else if (cursor_bad)
                            begin
                                res_next.status      = STS_BAD_CLUSTER;
                                res_next.cluster_out = cursor_reg;
                                file_open_next       = 1'b0;
                                state_next           = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FATW;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // read slot n while comparing slot n-1
                if (dir_rd_en)
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                cmp_vld_next  = dir_rd_en;
                cmp_slot_next = scan_cnt_reg[DAW-1:0];
                if (cmp_vld_reg && slot_hit)
                begin
                    cursor_next          = dir_rd_data.first_cluster;
                    bytes_left_next      = dir_rd_data.file_size;
                    file_open_next       = 1'b1;
                    res_next.status      = STS_OK;
                    res_next.found_slot  = 8'(cmp_slot_reg);
                    res_next.cluster_out = dir_rd_data.first_cluster;
                    res_next.size_out    = dir_rd_data.file_size;
                    res_next.sector      = su_res.sector;
                    state_next           = S_DONE;
                end
                else if (!dir_rd_en && !cmp_vld_reg)
                begin
                    file_open_next  = 1'b0;
                    res_next.status = STS_NOT_FOUND;
                    state_next      = S_DONE;
                end
            end

            S_FATW:
            begin
                res_next.status      = STS_OK;
                res_next.cluster_out = cursor_reg;
                res_next.size_out    = su_res.left;
                res_next.sector      = su_res.sector;
                res_next.byte_count  = su_res.count;
                res_next.last        = (fat_rd_data >= EOC_FIRST);
                bytes_left_next      = su_res.left;
                cursor_next          = fat_rd_data;
                if (fat_rd_data >= EOC_FIRST)
                begin
                    file_open_next = 1'b0;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_res_next   = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cursor_reg     <= '0;
            bytes_left_reg <= '0;
            file_open_reg  <= 1'b0;
            offset_reg     <= OFFSET_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            cursor_reg     <= cursor_next;
            bytes_left_reg <= bytes_left_next;
            file_open_reg  <= file_open_next;
            offset_reg     <= offset_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_slot_reg <= cmp_slot_next;
        res_reg      <= res_next;
        out_res_reg  <= out_res_next;
        key_head_reg <= key_head_next;
        key_tail_reg <= key_tail_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign found_slot  = out_res_reg.found_slot;
    assign cluster_out = out_res_reg.cluster_out;
    assign size_out    = out_res_reg.size_out;
    assign sector      = out_res_reg.sector;
    assign byte_count  = out_res_reg.byte_count;
    assign last        = out_res_reg.last;

    `FSW_ASSERT(a_busy_after_accept, accept |=> !in_ready, "accepted beat did not make block busy")
    `FSW_ASSERT(a_out_from_done, $rose(out_valid_reg) |-> $past(state_reg == S_DONE), "result without done state")
    `FSW_ASSERT_NEVER(a_scan_bound, scan_cnt_reg > CW'(DIR_ENTRIES), "scan counter past directory end")
    `FSW_ASSERT(a_fat_rd_range, fat_rd_en |-> (cursor_reg >= 12'd2 && {1'b0, cursor_reg} < 13'(FAT_ENTRIES)), "FAT read of unusable cluster")

endmodule

`default_nettype wire
